// File: src/one_wire_bus_master_top_assert.svh
// Assertion macros used by owm_core.
`ifndef ONE_WIRE_BUS_MASTER_TOP_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OWM_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("owm assertion failed");

// Next-cycle implication, disabled during reset.
`define OWM_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("owm assertion failed");

`endif

// File: src/owm_pkg.sv
`default_nettype none

package owm_pkg;

  localparam int REG_W           = 10;
  localparam int IDX_W           = 3;
  localparam int BITS_PER_BYTE   = 8;
  localparam int BIT_IDX_W       = $clog2(BITS_PER_BYTE);
  localparam int COUNT_WIDTH_DEF = 10;

  // func codes
  localparam logic [1:0] FUNC_NONE  = 2'd0;
  localparam logic [1:0] FUNC_RESET = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_RESET_LOW  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRES_SAMP  = 3'd1;
  localparam logic [IDX_W-1:0] REG_RESET_TAIL = 3'd2;
  localparam logic [IDX_W-1:0] REG_SLOT       = 3'd3;
  localparam logic [IDX_W-1:0] REG_WR1_LOW    = 3'd4;
  localparam logic [IDX_W-1:0] REG_WR0_LOW    = 3'd5;
  localparam logic [IDX_W-1:0] REG_RD_LOW     = 3'd6;
  localparam logic [IDX_W-1:0] REG_RD_SAMP    = 3'd7;

  // reset values
  localparam logic [REG_W-1:0] RST_RESET_LOW  = 10'd480;
  localparam logic [REG_W-1:0] RST_PRES_SAMP  = 10'd60;
  localparam logic [REG_W-1:0] RST_RESET_TAIL = 10'd420;
  localparam logic [REG_W-1:0] RST_SLOT       = 10'd61;
  localparam logic [REG_W-1:0] RST_WR1_LOW    = 10'd1;
  localparam logic [REG_W-1:0] RST_WR0_LOW    = 10'd60;
  localparam logic [REG_W-1:0] RST_RD_LOW     = 10'd1;
  localparam logic [REG_W-1:0] RST_RD_SAMP    = 10'd2;

  typedef struct packed {
    logic [REG_W-1:0] reset_low_ticks;
    logic [REG_W-1:0] presence_sample_ticks;
    logic [REG_W-1:0] reset_tail_ticks;
    logic [REG_W-1:0] slot_ticks;
    logic [REG_W-1:0] write_one_low_ticks;
    logic [REG_W-1:0] write_zero_low_ticks;
    logic [REG_W-1:0] read_low_ticks;
    logic [REG_W-1:0] read_sample_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] write_byte;
    logic       line_level;
  } item_t;

endpackage

`default_nettype wire

// File: src/owm_cfg_regs.sv
`default_nettype none

module owm_cfg_regs
  import owm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks       <= RST_RESET_LOW;
      cfg.presence_sample_ticks <= RST_PRES_SAMP;
      cfg.reset_tail_ticks      <= RST_RESET_TAIL;
      cfg.slot_ticks            <= RST_SLOT;
      cfg.write_one_low_ticks   <= RST_WR1_LOW;
      cfg.write_zero_low_ticks  <= RST_WR0_LOW;
      cfg.read_low_ticks        <= RST_RD_LOW;
      cfg.read_sample_ticks     <= RST_RD_SAMP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:  cfg.reset_low_ticks       <= cfg_data;
        REG_PRES_SAMP:  cfg.presence_sample_ticks <= cfg_data;
        REG_RESET_TAIL: cfg.reset_tail_ticks      <= cfg_data;
        REG_SLOT:       cfg.slot_ticks            <= cfg_data;
        REG_WR1_LOW:    cfg.write_one_low_ticks   <= cfg_data;
        REG_WR0_LOW:    cfg.write_zero_low_ticks  <= cfg_data;
        REG_RD_LOW:     cfg.read_low_ticks        <= cfg_data;
        REG_RD_SAMP:    cfg.read_sample_ticks     <= cfg_data;
        default:        ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/owm_core.sv
`default_nettype none
`include "one_wire_bus_master_top_assert.svh"

module owm_core
  import owm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic in_full,
  input  wire item_t item,
  output logic      advance,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic      pull_low,
  output logic      busy_res,
  output logic      done_res,
  output logic      presence,
  output logic [7:0] read_data
);

  localparam int CW = COUNT_WIDTH;

  typedef enum logic [2:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_SLOT
  } phase_t;

  phase_t               phase, phase_next;
  logic [1:0]           operation, operation_next;
  logic [CW-1:0]        tick_count, tick_count_next;
  logic [BIT_IDX_W-1:0] bit_index, bit_index_next;
  logic [7:0]           shift_reg, shift_reg_next;
  logic                 presence_flag, presence_flag_next;
  logic [7:0]           last_read, last_read_next;
  logic                 pl, busy, done;
  logic                 step;

  // zero acts as one; value cut to the counter width
  function automatic logic [CW-1:0] eff_of(input logic [REG_W-1:0] v);
    logic [CW-1:0] c;
    c = CW'(v);
    return (c == '0) ? CW'(1) : c;
  endfunction

  logic [CW-1:0] e_rst_low, e_pres, e_tail, e_slot, e_wr1, e_wr0, e_rd_low, e_rd_samp;

  assign e_rst_low = eff_of(cfg.reset_low_ticks);
  assign e_pres    = eff_of(cfg.presence_sample_ticks);
  assign e_tail    = eff_of(cfg.reset_tail_ticks);
  assign e_slot    = eff_of(cfg.slot_ticks);
  assign e_wr1     = eff_of(cfg.write_one_low_ticks);
  assign e_wr0     = eff_of(cfg.write_zero_low_ticks);
  assign e_rd_low  = eff_of(cfg.read_low_ticks);
  assign e_rd_samp = eff_of(cfg.read_sample_ticks);

  assign advance = !out_valid || !out_stall;
  assign step    = in_full && advance;

  always_comb begin
    logic [CW-1:0] limit;
    logic [CW-1:0] low_len;
    logic [CW-1:0] sample_at;
    logic          last_tick;
    logic          finish;

    phase_next         = phase;
    operation_next     = operation;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_reg_next     = shift_reg;
    presence_flag_next = presence_flag;
    last_read_next     = last_read;
    pl                 = 1'b0;
    busy               = 1'b0;
    done               = 1'b0;
    finish             = 1'b0;
    limit              = e_rst_low;
    low_len            = e_rd_low;
    sample_at          = e_rd_samp;

    // a command taken while idle is also the first tick of its operation
    if (phase == PH_IDLE && item.func != FUNC_NONE) begin
      operation_next  = item.func;
      tick_count_next = '0;
      bit_index_next  = '0;
      if (item.func == FUNC_RESET) begin
        phase_next = PH_RST_LOW;
      end else begin
        phase_next     = PH_SLOT;
        shift_reg_next = (item.func == FUNC_WRITE) ? item.write_byte : 8'h00;
      end
    end

    unique case (phase_next)
      PH_RST_LOW:  limit = e_rst_low;
      PH_RST_WAIT: limit = e_pres;
      PH_RST_TAIL: limit = e_tail;
      default:     limit = e_slot;
    endcase
    last_tick = ((CW+1)'(tick_count_next) + 1'b1) >= (CW+1)'(limit);

    if (operation_next == FUNC_WRITE) begin
      low_len = shift_reg_next[0] ? e_wr1 : e_wr0;
    end
    // late sample clamps to the slot's last tick
    if (e_rd_samp > e_slot - 1'b1) begin
      sample_at = e_slot - 1'b1;
    end

    if (phase_next != PH_IDLE) begin
      busy = 1'b1;
      unique case (phase_next)
        PH_RST_LOW: begin
          pl = 1'b1;
          if (last_tick) begin
            phase_next      = PH_RST_WAIT;
            tick_count_next = '0;
          end else begin
            tick_count_next = tick_count_next + 1'b1;
          end
        end
        PH_RST_WAIT: begin
          if (last_tick) begin
            presence_flag_next = !item.line_level;
            phase_next         = PH_RST_TAIL;
            tick_count_next    = '0;
          end else begin
            tick_count_next = tick_count_next + 1'b1;
          end
        end
        PH_RST_TAIL: begin
          if (last_tick) begin
            finish = 1'b1;
          end else begin
            tick_count_next = tick_count_next + 1'b1;
          end
        end
        default: begin
          pl = (tick_count_next < low_len);
          if (operation_next == FUNC_READ && tick_count_next == sample_at) begin
            shift_reg_next = {item.line_level, shift_reg_next[7:1]};
          end
          if (last_tick) begin
            if (operation_next == FUNC_WRITE) begin
              shift_reg_next = {1'b0, shift_reg_next[7:1]};
            end
            tick_count_next = '0;
            if (bit_index_next == BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
              finish = 1'b1;
            end else begin
              bit_index_next = bit_index_next + 1'b1;
            end
          end else begin
            tick_count_next = tick_count_next + 1'b1;
          end
        end
      endcase
      if (finish) begin
        done = 1'b1;
        if (operation_next == FUNC_READ) begin
          last_read_next = shift_reg_next;
        end
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      operation     <= FUNC_NONE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_reg     <= '0;
      presence_flag <= 1'b0;
      last_read     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= in_full;
      end
      if (step) begin
        phase         <= phase_next;
        operation     <= operation_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        shift_reg     <= shift_reg_next;
        presence_flag <= presence_flag_next;
        last_read     <= last_read_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pull_low  <= pl;
      busy_res  <= busy;
      done_res  <= done;
      presence  <= presence_flag_next;
      read_data <= last_read_next;
    end
  end

  `OWM_ASSERT_IMPLIES(a_idle_count_clear, clk, rst, phase == PH_IDLE, tick_count == '0)
  `OWM_ASSERT_IMPLIES(a_done_busy, clk, rst, out_valid && done_res, busy_res)
  `OWM_ASSERT_IMPLIES(a_drive_busy, clk, rst, out_valid && pull_low, busy_res)
  `OWM_ASSERT_NEXT(a_hold_no_step, clk, rst, !step, $stable(tick_count) && $stable(phase))
  `OWM_ASSERT_IMPLIES(a_read_only_done, clk, rst, step && last_read_next != last_read,
                      done && operation_next == FUNC_READ)

endmodule

`default_nettype wire

// File: src/one_wire_bus_master_top.sv
// 1-Wire bus master, one input transfer per bus tick.
// An accepted tick is held in the input register; the state update and the result
// register then take it in a single pass.
// Throughput: one tick per clock; only a stalled result register holds the input.
// Reset (rst, synchronous, active high): idle, out_valid low, internal presence
// and read byte cleared (outputs kept), delay regs to defaults. No clearing pass.
`default_nettype none

module one_wire_bus_master_top
  import owm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       func,
  input  wire logic [7:0]       write_byte,
  input  wire logic             line_level,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  pull_low,
  output logic                  busy_res,
  output logic                  done_res,
  output logic                  presence,
  output logic [7:0]            read_data,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_data
);

  cfg_t  cfg;
  item_t item;
  logic  in_full;
  logic  advance;
  logic  in_take;

  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.func       <= func;
      item.write_byte <= write_byte;
      item.line_level <= line_level;
    end
  end

  owm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owm_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_full   (in_full),
    .item      (item),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pull_low  (pull_low),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .presence  (presence),
    .read_data (read_data)
  );

endmodule

`default_nettype wire
